FILE: design/cfre_pkg.sv
// Shared types, constants and rounding helpers for the camera-facing ribbon expander.
package cfre_pkg;

   // Configuration register indexes.
   localparam logic [2:0] CSR_CAMERA_X      = 3'd0;
   localparam logic [2:0] CSR_CAMERA_Y      = 3'd1;
   localparam logic [2:0] CSR_CAMERA_Z      = 3'd2;
   localparam logic [2:0] CSR_SKIP_THR      = 3'd3;
   localparam logic [2:0] CSR_SMALL_THR     = 3'd4;

   // Reset values of the camera and threshold registers.
   localparam logic signed [23:0] CAMERA_Z_RESET  = 24'sd65536;
   localparam logic [15:0]        SMALL_THR_RESET = 16'd4295;

   // Fixed-point constants.
   localparam logic signed [17:0] UNIT_ONE         = 18'sd65536;
   localparam logic signed [17:0] FALLBACK_Y_LIMIT = 18'sd62259;
   localparam logic signed [23:0] POS_MAX          = 24'sd8388607;
   localparam logic signed [23:0] POS_MIN          = -24'sd8388608;

   // Index of the sixth vertex of a ribbon.
   localparam logic [2:0] LAST_VERTEX = 3'd5;

   typedef struct packed {
      logic signed [23:0] camera_x;
      logic signed [23:0] camera_y;
      logic signed [23:0] camera_z;
      logic [15:0]        skip_thr;
      logic [15:0]        small_thr;
   } cfg_type;

   // One segment as it arrives.
   typedef struct packed {
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic signed [23:0] ex;
      logic signed [23:0] ey;
      logic [22:0]        hs;
      logic [22:0]        he;
      logic [15:0]        r;
      logic [15:0]        g;
      logic [15:0]        b;
   } seg_in_type;

   // One classified segment handed from the front to the solver.
   typedef struct packed {
      seg_in_type         raw;
      logic signed [24:0] dx;
      logic signed [24:0] dy;
      logic signed [26:0] wx;
      logic signed [26:0] wy;
      logic signed [26:0] wz;
      logic [49:0]        seg_sq;
      logic [51:0]        w_sq;
      logic               seg_small;
      logic               view_small;
   } seg_type;

   // Four ribbon corners: start-left, start-right, end-left, end-right.
   typedef struct packed {
      logic [3:0][23:0] px;
      logic [3:0][23:0] py;
      logic [3:0][23:0] pz;
      logic [15:0]      r;
      logic [15:0]      g;
      logic [15:0]      b;
   } ribbon_type;

   // Shift right with rounding half away from zero.
   function automatic logic signed [47:0] round_shr(input logic signed [47:0] v, input int sh);
      logic [47:0] mag;
      logic [47:0] q;
      mag = v[47] ? $unsigned(-v) : $unsigned(v);
      q   = (mag + (48'd1 << (sh - 1))) >> sh;
      return v[47] ? -$signed(q) : $signed(q);
   endfunction

   // Clamp to the 24 bit signed position range.
   function automatic logic [23:0] sat24(input logic signed [26:0] v);
      logic [23:0] res;
      if (v > 27'(POS_MAX)) begin
         res = POS_MAX;
      end else if (v < 27'(POS_MIN)) begin
         res = POS_MIN;
      end else begin
         res = v[23:0];
      end
      return res;
   endfunction

   // Corner shown at each vertex of the two triangles.
   function automatic logic [1:0] corner_of(input logic [2:0] k);
      logic [1:0] c;
      unique case (k)
         3'd0:    c = 2'd0;
         3'd1:    c = 2'd2;
         3'd2:    c = 2'd3;
         3'd3:    c = 2'd0;
         3'd4:    c = 2'd3;
         3'd5:    c = 2'd1;
         default: c = 2'd0;
      endcase
      return c;
   endfunction

endpackage

FILE: design/cfre_front.sv
// Front pipeline: takes segments, forms differences and squared lengths, drops short ones.
module cfre_front (
   input  logic              clock,
   input  logic              reset,
   input  cfre_pkg::cfg_type cfg,
   input  logic              req_push,
   output logic              req_full,
   input  cfre_pkg::seg_in_type req_data,
   output logic              q_push,
   output cfre_pkg::seg_type q_data,
   input  logic              q_full
);
   import cfre_pkg::*;

   logic s1_v_ff, s1_v_in, s2_v_ff, s2_v_in, s3_v_ff, s3_v_in;
   logic s1_en, s2_en, s3_en, s3_go;
   seg_in_type s1_ff, s2_raw_ff, s3_raw_ff;
   logic signed [24:0] dx_ff, dy_ff, s3_dx_ff, s3_dy_ff;
   logic signed [26:0] wx_ff, wy_ff, wz_ff, s3_wx_ff, s3_wy_ff, s3_wz_ff;
   logic [48:0] dxx_ff, dyy_ff;
   logic [50:0] wxx_ff, wyy_ff, wzz_ff;
   logic signed [49:0] m_dx, m_dy;
   logic signed [53:0] m_wx, m_wy, m_wz;
   logic [49:0] seg_sq;
   logic [51:0] w_sq;
   logic skip;

   // Stage enables: a stage moves when the one after it is free or moving.
   assign s3_go = s3_v_ff && (skip || !q_full);
   assign s3_en = !s3_v_ff || s3_go;
   assign s2_en = !s2_v_ff || s3_en;
   assign s1_en = !s1_v_ff || s2_en;
   assign req_full = !s1_en;

   assign s1_v_in = s1_en ? req_push : s1_v_ff;
   assign s2_v_in = s2_en ? s1_v_ff : s2_v_ff;
   assign s3_v_in = s3_en ? s2_v_ff : s3_v_ff;

   // Squares of the differences.
   assign m_dx = dx_ff * dx_ff;
   assign m_dy = dy_ff * dy_ff;
   assign m_wx = wx_ff * wx_ff;
   assign m_wy = wy_ff * wy_ff;
   assign m_wz = wz_ff * wz_ff;

   // Squared lengths and classification of the segment.
   assign seg_sq = {1'b0, dxx_ff} + {1'b0, dyy_ff};
   assign w_sq   = {1'b0, wxx_ff} + {1'b0, wyy_ff} + {1'b0, wzz_ff};
   assign skip   = seg_sq <= {34'd0, cfg.skip_thr};

   assign q_push = s3_v_ff && !skip && !q_full;
   always_comb begin
      q_data.raw        = s3_raw_ff;
      q_data.dx         = s3_dx_ff;
      q_data.dy         = s3_dy_ff;
      q_data.wx         = s3_wx_ff;
      q_data.wy         = s3_wy_ff;
      q_data.wz         = s3_wz_ff;
      q_data.seg_sq     = seg_sq;
      q_data.w_sq       = w_sq;
      q_data.seg_small  = seg_sq <= {34'd0, cfg.small_thr};
      q_data.view_small = w_sq <= {34'd0, cfg.small_thr, 2'b00};
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
         s2_v_ff <= s2_v_in;
         s3_v_ff <= s3_v_in;
      end
   end

   // Payload stages.
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff <= req_data;
      end
      if (s2_en) begin
         s2_raw_ff <= s1_ff;
         dx_ff     <= 25'(s1_ff.ex) - 25'(s1_ff.sx);
         dy_ff     <= 25'(s1_ff.ey) - 25'(s1_ff.sy);
         wx_ff     <= (27'(cfg.camera_x) + 27'(cfg.camera_x)) - (27'(s1_ff.sx) + 27'(s1_ff.ex));
         wy_ff     <= (27'(cfg.camera_y) + 27'(cfg.camera_y)) - (27'(s1_ff.sy) + 27'(s1_ff.ey));
         wz_ff     <= 27'(cfg.camera_z) + 27'(cfg.camera_z);
      end
      if (s3_en) begin
         s3_raw_ff <= s2_raw_ff;
         s3_dx_ff  <= dx_ff;
         s3_dy_ff  <= dy_ff;
         s3_wx_ff  <= wx_ff;
         s3_wy_ff  <= wy_ff;
         s3_wz_ff  <= wz_ff;
         dxx_ff    <= m_dx[48:0];
         dyy_ff    <= m_dy[48:0];
         wxx_ff    <= m_wx[50:0];
         wyy_ff    <= m_wy[50:0];
         wzz_ff    <= m_wz[50:0];
      end
   end

endmodule

FILE: design/cfre_queue.sv
// Short queue of classified segments between the front and the solver.
module cfre_queue #(
   parameter int DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cfre_pkg::seg_type push_data,
   output logic              full,
   input  logic              pop,
   output cfre_pkg::seg_type pop_data,
   output logic              empty
);
   import cfre_pkg::*;

   localparam int PW   = $clog2(DEPTH);
   localparam int CNTW = $clog2(DEPTH + 1);

   seg_type mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0] count_ff, count_in;

   assign full     = count_ff == CNTW'(DEPTH);
   assign empty    = count_ff == '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset) push |-> !full || pop)
      else $error("queue written while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("queue read while empty");

endmodule

FILE: design/cfre_solver.sv
// Side vector solver: shared square root and divide units, cross product and corner math.
module cfre_solver (
   input  logic                 clock,
   input  logic                 reset,
   input  cfre_pkg::cfg_type    cfg,
   input  logic                 q_empty,
   input  cfre_pkg::seg_type    q_data,
   output logic                 q_pop,
   output logic                 rib_valid,
   output cfre_pkg::ribbon_type rib_data,
   input  logic                 rib_take
);
   import cfre_pkg::*;

   localparam logic [3:0] ST_IDLE      = 4'd0;
   localparam logic [3:0] ST_SQRT      = 4'd1;
   localparam logic [3:0] ST_DIV       = 4'd2;
   localparam logic [3:0] ST_CROSS_MUL = 4'd3;
   localparam logic [3:0] ST_CROSS_SUM = 4'd4;
   localparam logic [3:0] ST_CSQ_MUL   = 4'd5;
   localparam logic [3:0] ST_CSQ_SUM   = 4'd6;
   localparam logic [3:0] ST_OFS_MUL   = 4'd7;
   localparam logic [3:0] ST_OFS_RND   = 4'd8;
   localparam logic [3:0] ST_CORNER    = 4'd9;
   localparam logic [3:0] ST_HAND      = 4'd10;

   localparam logic [1:0] SQ_SEG   = 2'd0;
   localparam logic [1:0] SQ_VIEW  = 2'd1;
   localparam logic [1:0] SQ_CROSS = 2'd2;

   localparam logic [2:0] OP_UX = 3'd0;
   localparam logic [2:0] OP_UY = 3'd1;
   localparam logic [2:0] OP_VX = 3'd2;
   localparam logic [2:0] OP_VY = 3'd3;
   localparam logic [2:0] OP_VZ = 3'd4;
   localparam logic [2:0] OP_RX = 3'd5;
   localparam logic [2:0] OP_RY = 3'd6;
   localparam logic [2:0] OP_RZ = 3'd7;

   localparam logic [51:0] SQ_BIT_TOP   = 52'd1 << 50;
   localparam logic [4:0]  SQ_STEPS     = 5'd25;
   localparam logic [4:0]  DIV_STEPS    = 5'd16;

   logic [3:0] state_ff, state_in;
   seg_type seg_ff, seg_in;

   // Square root unit.
   logic [1:0]  sq_sel_ff, sq_sel_in;
   logic [51:0] sq_n_ff, sq_n_in, sq_root_ff, sq_root_in, sq_bit_ff, sq_bit_in;
   logic [4:0]  sq_cnt_ff, sq_cnt_in;

   // Divide unit.
   logic [2:0]  div_op_ff, div_op_in;
   logic [26:0] div_den_ff, div_den_in;
   logic [43:0] div_rem_ff, div_rem_in, div_dsh_ff, div_dsh_in;
   logic [16:0] div_q_ff, div_q_in;
   logic [4:0]  div_cnt_ff, div_cnt_in;
   logic        div_neg_ff, div_neg_in;

   // Unit vectors.
   logic signed [17:0] ux_ff, ux_in, uy_ff, uy_in;
   logic signed [17:0] vx_ff, vx_in, vy_ff, vy_in, vz_ff, vz_in;
   logic signed [17:0] rx_ff, rx_in, ry_ff, ry_in, rz_ff, rz_in;

   // Cross product.
   logic signed [35:0] p_uyvz_ff, p_uyvz_in, p_uxvz_ff, p_uxvz_in;
   logic signed [35:0] p_uxvy_ff, p_uxvy_in, p_uyvx_ff, p_uyvx_in;
   logic signed [26:0] cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [51:0] cxx_ff, cxx_in, cyy_ff, cyy_in, czz_ff, czz_in;

   // Offsets.
   logic signed [41:0] pxs_ff, pxs_in, pys_ff, pys_in, pzs_ff, pzs_in;
   logic signed [41:0] pxe_ff, pxe_in, pye_ff, pye_in, pze_ff, pze_in;
   logic signed [24:0] osx_ff, osx_in, osy_ff, osy_in, osz_ff, osz_in;
   logic signed [24:0] oex_ff, oex_in, oey_ff, oey_in, oez_ff, oez_in;

   ribbon_type rib_ff, rib_in;

   // Rounded numerator loaded into the divider: |num| * 2^16 + den / 2.
   function automatic logic [43:0] rem_start(input logic signed [26:0] num,
                                             input logic [26:0] den);
      logic [26:0] mag;
      mag = num[26] ? $unsigned(-num) : $unsigned(num);
      return {1'b0, mag, 16'd0} + {17'd0, den >> 1};
   endfunction

   assign rib_valid = state_ff == ST_HAND;
   assign rib_data  = rib_ff;

   always_comb begin
      logic [52:0] sq_sum;
      logic        sq_ge;
      logic [51:0] root_next;
      logic        div_ge;
      logic [16:0] q_next;
      logic signed [17:0] quot;
      logic        do_sq;
      logic [51:0] sq_val;
      logic [1:0]  sq_sel;
      logic        do_div;
      logic [2:0]  div_op;
      logic [26:0] div_den;
      logic signed [26:0] div_num;
      logic signed [47:0] t0, t1, t2, t3, t4, t5;
      logic signed [53:0] m0, m1, m2;
      logic [51:0] c_sq;
      logic        fb_in_range, fb_neg;

      state_in   = state_ff;
      seg_in     = seg_ff;
      sq_sel_in  = sq_sel_ff;
      sq_n_in    = sq_n_ff;
      sq_root_in = sq_root_ff;
      sq_bit_in  = sq_bit_ff;
      sq_cnt_in  = sq_cnt_ff;
      div_op_in  = div_op_ff;
      div_den_in = div_den_ff;
      div_rem_in = div_rem_ff;
      div_dsh_in = div_dsh_ff;
      div_q_in   = div_q_ff;
      div_cnt_in = div_cnt_ff;
      div_neg_in = div_neg_ff;
      ux_in = ux_ff;  uy_in = uy_ff;
      vx_in = vx_ff;  vy_in = vy_ff;  vz_in = vz_ff;
      rx_in = rx_ff;  ry_in = ry_ff;  rz_in = rz_ff;
      p_uyvz_in = p_uyvz_ff;  p_uxvz_in = p_uxvz_ff;
      p_uxvy_in = p_uxvy_ff;  p_uyvx_in = p_uyvx_ff;
      cx_in = cx_ff;  cy_in = cy_ff;  cz_in = cz_ff;
      cxx_in = cxx_ff;  cyy_in = cyy_ff;  czz_in = czz_ff;
      pxs_in = pxs_ff;  pys_in = pys_ff;  pzs_in = pzs_ff;
      pxe_in = pxe_ff;  pye_in = pye_ff;  pze_in = pze_ff;
      osx_in = osx_ff;  osy_in = osy_ff;  osz_in = osz_ff;
      oex_in = oex_ff;  oey_in = oey_ff;  oez_in = oez_ff;
      rib_in = rib_ff;
      q_pop  = 1'b0;

      do_sq   = 1'b0;
      sq_val  = '0;
      sq_sel  = SQ_SEG;
      do_div  = 1'b0;
      div_op  = OP_UX;
      div_den = div_den_ff;
      div_num = '0;

      // One square root step: one result bit per cycle.
      sq_sum    = {1'b0, sq_root_ff} + {1'b0, sq_bit_ff};
      sq_ge     = {1'b0, sq_n_ff} >= sq_sum;
      root_next = sq_ge ? (sq_root_ff >> 1) + sq_bit_ff : sq_root_ff >> 1;

      // One restoring divide step: one quotient bit per cycle.
      div_ge = div_rem_ff >= div_dsh_ff;
      q_next = {div_q_ff[15:0], div_ge};
      quot   = div_neg_ff ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});

      t0 = '0;  t1 = '0;  t2 = '0;  t3 = '0;  t4 = '0;  t5 = '0;
      m0 = '0;  m1 = '0;  m2 = '0;
      c_sq = '0;
      fb_in_range = 1'b0;
      fb_neg      = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               seg_in = q_data;
               if (q_data.seg_small) begin
                  rx_in    = '0;
                  ry_in    = UNIT_ONE;
                  rz_in    = '0;
                  state_in = ST_OFS_MUL;
               end else begin
                  do_sq  = 1'b1;
                  sq_val = {2'b00, q_data.seg_sq};
                  sq_sel = SQ_SEG;
               end
            end
         end

         ST_SQRT: begin
            sq_n_in    = sq_ge ? sq_n_ff - sq_sum[51:0] : sq_n_ff;
            sq_root_in = root_next;
            sq_bit_in  = sq_bit_ff >> 2;
            sq_cnt_in  = sq_cnt_ff - 1'b1;
            if (sq_cnt_ff == '0) begin
               do_div  = 1'b1;
               div_den = root_next[26:0];
               unique case (sq_sel_ff)
                  SQ_SEG:   div_op = OP_UX;
                  SQ_VIEW:  div_op = OP_VX;
                  SQ_CROSS: div_op = OP_RX;
                  default:  div_op = OP_RX;
               endcase
            end
         end

         ST_DIV: begin
            div_rem_in = div_ge ? div_rem_ff - div_dsh_ff : div_rem_ff;
            div_dsh_in = div_dsh_ff >> 1;
            div_q_in   = q_next;
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == '0) begin
               unique case (div_op_ff)
                  OP_UX: begin
                     ux_in  = quot;
                     do_div = 1'b1;
                     div_op = OP_UY;
                  end
                  OP_UY: begin
                     uy_in = quot;
                     if (seg_ff.view_small) begin
                        vx_in    = '0;
                        vy_in    = '0;
                        vz_in    = UNIT_ONE;
                        state_in = ST_CROSS_MUL;
                     end else begin
                        do_sq  = 1'b1;
                        sq_val = seg_ff.w_sq;
                        sq_sel = SQ_VIEW;
                     end
                  end
                  OP_VX: begin
                     vx_in  = quot;
                     do_div = 1'b1;
                     div_op = OP_VY;
                  end
                  OP_VY: begin
                     vy_in  = quot;
                     do_div = 1'b1;
                     div_op = OP_VZ;
                  end
                  OP_VZ: begin
                     vz_in    = quot;
                     state_in = ST_CROSS_MUL;
                  end
                  OP_RX: begin
                     rx_in  = quot;
                     do_div = 1'b1;
                     div_op = OP_RY;
                  end
                  OP_RY: begin
                     ry_in  = quot;
                     do_div = 1'b1;
                     div_op = OP_RZ;
                  end
                  OP_RZ: begin
                     rz_in    = quot;
                     state_in = ST_OFS_MUL;
                  end
                  default: state_in = ST_OFS_MUL;
               endcase
            end
         end

         // Partial products of u x v (u has no z component).
         ST_CROSS_MUL: begin
            p_uyvz_in = uy_ff * vz_ff;
            p_uxvz_in = ux_ff * vz_ff;
            p_uxvy_in = ux_ff * vy_ff;
            p_uyvx_in = uy_ff * vx_ff;
            state_in  = ST_CROSS_SUM;
         end

         // Cross product rounded to 2^-24 units.
         ST_CROSS_SUM: begin
            t0 = round_shr(48'(p_uyvz_ff), 8);
            t1 = round_shr(-48'(p_uxvz_ff), 8);
            t2 = round_shr(48'(p_uxvy_ff) - 48'(p_uyvx_ff), 8);
            cx_in    = t0[26:0];
            cy_in    = t1[26:0];
            cz_in    = t2[26:0];
            state_in = ST_CSQ_MUL;
         end

         ST_CSQ_MUL: begin
            m0 = cx_ff * cx_ff;
            m1 = cy_ff * cy_ff;
            m2 = cz_ff * cz_ff;
            cxx_in   = m0[51:0];
            cyy_in   = m1[51:0];
            czz_in   = m2[51:0];
            state_in = ST_CSQ_SUM;
         end

         // Degenerate cross product falls back to a z-axis side vector.
         ST_CSQ_SUM: begin
            c_sq = cxx_ff + cyy_ff + czz_ff;
            if (c_sq <= {20'd0, cfg.small_thr, 16'd0}) begin
               fb_in_range = (uy_ff < FALLBACK_Y_LIMIT) && (uy_ff > -FALLBACK_Y_LIMIT);
               fb_neg      = fb_in_range ? ux_ff[17] : (uy_ff > 18'sd0);
               rx_in    = '0;
               ry_in    = '0;
               rz_in    = fb_neg ? -UNIT_ONE : UNIT_ONE;
               state_in = ST_OFS_MUL;
            end else begin
               do_sq  = 1'b1;
               sq_val = c_sq;
               sq_sel = SQ_CROSS;
            end
         end

         ST_OFS_MUL: begin
            pxs_in   = rx_ff * $signed({1'b0, seg_ff.raw.hs});
            pys_in   = ry_ff * $signed({1'b0, seg_ff.raw.hs});
            pzs_in   = rz_ff * $signed({1'b0, seg_ff.raw.hs});
            pxe_in   = rx_ff * $signed({1'b0, seg_ff.raw.he});
            pye_in   = ry_ff * $signed({1'b0, seg_ff.raw.he});
            pze_in   = rz_ff * $signed({1'b0, seg_ff.raw.he});
            state_in = ST_OFS_RND;
         end

         ST_OFS_RND: begin
            t0 = round_shr(48'(pxs_ff), 16);
            t1 = round_shr(48'(pys_ff), 16);
            t2 = round_shr(48'(pzs_ff), 16);
            t3 = round_shr(48'(pxe_ff), 16);
            t4 = round_shr(48'(pye_ff), 16);
            t5 = round_shr(48'(pze_ff), 16);
            osx_in = t0[24:0];
            osy_in = t1[24:0];
            osz_in = t2[24:0];
            oex_in = t3[24:0];
            oey_in = t4[24:0];
            oez_in = t5[24:0];
            state_in = ST_CORNER;
         end

         // Corners moved by the offsets and saturated.
         ST_CORNER: begin
            rib_in.px[0] = sat24(27'(seg_ff.raw.sx) - 27'(osx_ff));
            rib_in.py[0] = sat24(27'(seg_ff.raw.sy) - 27'(osy_ff));
            rib_in.pz[0] = sat24(-27'(osz_ff));
            rib_in.px[1] = sat24(27'(seg_ff.raw.sx) + 27'(osx_ff));
            rib_in.py[1] = sat24(27'(seg_ff.raw.sy) + 27'(osy_ff));
            rib_in.pz[1] = sat24(27'(osz_ff));
            rib_in.px[2] = sat24(27'(seg_ff.raw.ex) - 27'(oex_ff));
            rib_in.py[2] = sat24(27'(seg_ff.raw.ey) - 27'(oey_ff));
            rib_in.pz[2] = sat24(-27'(oez_ff));
            rib_in.px[3] = sat24(27'(seg_ff.raw.ex) + 27'(oex_ff));
            rib_in.py[3] = sat24(27'(seg_ff.raw.ey) + 27'(oey_ff));
            rib_in.pz[3] = sat24(27'(oez_ff));
            rib_in.r = seg_ff.raw.r;
            rib_in.g = seg_ff.raw.g;
            rib_in.b = seg_ff.raw.b;
            state_in = ST_HAND;
         end

         ST_HAND: begin
            if (rib_take) begin
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      // Launch the square root unit.
      if (do_sq) begin
         sq_n_in    = sq_val;
         sq_root_in = '0;
         sq_bit_in  = SQ_BIT_TOP;
         sq_cnt_in  = SQ_STEPS;
         sq_sel_in  = sq_sel;
         state_in   = ST_SQRT;
      end

      // Launch the divide unit with the numerator of the chosen component.
      if (do_div) begin
         unique case (div_op)
            OP_UX:   div_num = 27'(seg_ff.dx);
            OP_UY:   div_num = 27'(seg_ff.dy);
            OP_VX:   div_num = seg_ff.wx;
            OP_VY:   div_num = seg_ff.wy;
            OP_VZ:   div_num = seg_ff.wz;
            OP_RX:   div_num = cx_ff;
            OP_RY:   div_num = cy_ff;
            OP_RZ:   div_num = cz_ff;
            default: div_num = cz_ff;
         endcase
         div_op_in  = div_op;
         div_den_in = div_den;
         div_dsh_in = {1'b0, div_den, 16'd0};
         div_rem_in = rem_start(div_num, div_den);
         div_neg_in = div_num[26];
         div_q_in   = '0;
         div_cnt_in = DIV_STEPS;
         state_in   = ST_DIV;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      seg_ff     <= seg_in;
      sq_sel_ff  <= sq_sel_in;
      sq_n_ff    <= sq_n_in;
      sq_root_ff <= sq_root_in;
      sq_bit_ff  <= sq_bit_in;
      sq_cnt_ff  <= sq_cnt_in;
      div_op_ff  <= div_op_in;
      div_den_ff <= div_den_in;
      div_rem_ff <= div_rem_in;
      div_dsh_ff <= div_dsh_in;
      div_q_ff   <= div_q_in;
      div_cnt_ff <= div_cnt_in;
      div_neg_ff <= div_neg_in;
      ux_ff <= ux_in;  uy_ff <= uy_in;
      vx_ff <= vx_in;  vy_ff <= vy_in;  vz_ff <= vz_in;
      rx_ff <= rx_in;  ry_ff <= ry_in;  rz_ff <= rz_in;
      p_uyvz_ff <= p_uyvz_in;  p_uxvz_ff <= p_uxvz_in;
      p_uxvy_ff <= p_uxvy_in;  p_uyvx_ff <= p_uyvx_in;
      cx_ff <= cx_in;  cy_ff <= cy_in;  cz_ff <= cz_in;
      cxx_ff <= cxx_in;  cyy_ff <= cyy_in;  czz_ff <= czz_in;
      pxs_ff <= pxs_in;  pys_ff <= pys_in;  pzs_ff <= pzs_in;
      pxe_ff <= pxe_in;  pye_ff <= pye_in;  pze_ff <= pze_in;
      osx_ff <= osx_in;  osy_ff <= osy_in;  osz_ff <= osz_in;
      oex_ff <= oex_in;  oey_ff <= oey_in;  oez_ff <= oez_in;
      rib_ff <= rib_in;
   end

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == ST_IDLE) && !q_empty)
      else $error("solver took a segment while busy");

endmodule

FILE: design/cfre_emit.sv
// Vertex emitter: holds one finished ribbon and hands out its six vertices.
module cfre_emit (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rib_valid,
   input  cfre_pkg::ribbon_type rib_data,
   output logic                 rib_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic signed [23:0]   rsp_pos_x,
   output logic signed [23:0]   rsp_pos_y,
   output logic signed [23:0]   rsp_pos_z,
   output logic [15:0]          rsp_color_r,
   output logic [15:0]          rsp_color_g,
   output logic [15:0]          rsp_color_b,
   output logic                 rsp_side,
   output logic                 rsp_last
);
   import cfre_pkg::*;

   logic       v_ff, v_in;
   logic [2:0] cnt_ff, cnt_in;
   ribbon_type rib_ff;
   logic [1:0] corner;
   logic       done;

   // A new ribbon enters when the buffer is free or its last vertex leaves now.
   assign done     = v_ff && rsp_pop && (cnt_ff == LAST_VERTEX);
   assign rib_take = rib_valid && (!v_ff || done);

   always_comb begin
      v_in   = v_ff;
      cnt_in = cnt_ff;
      if (rib_take) begin
         v_in   = 1'b1;
         cnt_in = '0;
      end else if (done) begin
         v_in   = 1'b0;
         cnt_in = '0;
      end else if (v_ff && rsp_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff   <= 1'b0;
         cnt_ff <= '0;
      end else begin
         v_ff   <= v_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rib_take) begin
         rib_ff <= rib_data;
      end
   end

   // Current vertex.
   assign corner      = corner_of(cnt_ff);
   assign rsp_empty   = !v_ff;
   assign rsp_pos_x   = rib_ff.px[corner];
   assign rsp_pos_y   = rib_ff.py[corner];
   assign rsp_pos_z   = rib_ff.pz[corner];
   assign rsp_color_r = rib_ff.r;
   assign rsp_color_g = rib_ff.g;
   assign rsp_color_b = rib_ff.b;
   assign rsp_side    = corner[0];
   assign rsp_last    = cnt_ff == LAST_VERTEX;

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (rsp_pop && !rsp_empty && rsp_last) |=> (cnt_ff == 3'd0))
      else $error("vertex count did not restart after the last vertex");
   a_take_fills: assert property (@(posedge clock) disable iff (reset)
      rib_take |=> !rsp_empty)
      else $error("ribbon taken but no vertex shown");

endmodule

FILE: design/camera_facing_ribbon_expander_unit.sv
// Top level of the camera-facing ribbon expander: CSR file, front, queue, solver, emitter.
// A segment at or below the small threshold bypasses the square root and divide units;
// every other segment passes through the shared one-bit-per-cycle square root and divide
// units in the solver. The solver takes one segment per pass and takes no new one until
// its ribbon has been handed to the emitter; skipped segments leave the front at one per
// cycle unless a kept segment ahead of them waits on a full queue. Synchronous active-high
// reset clears control state and CSRs.
module camera_facing_ribbon_expander_unit #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_data,
   input  logic                req_push,
   output logic                req_full,
   input  logic signed [23:0]  req_start_x,
   input  logic signed [23:0]  req_start_y,
   input  logic signed [23:0]  req_end_x,
   input  logic signed [23:0]  req_end_y,
   input  logic [22:0]         req_start_half_width,
   input  logic [22:0]         req_end_half_width,
   input  logic [15:0]         req_tint_r,
   input  logic [15:0]         req_tint_g,
   input  logic [15:0]         req_tint_b,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output logic signed [23:0]  rsp_pos_x,
   output logic signed [23:0]  rsp_pos_y,
   output logic signed [23:0]  rsp_pos_z,
   output logic [15:0]         rsp_color_r,
   output logic [15:0]         rsp_color_g,
   output logic [15:0]         rsp_color_b,
   output logic                rsp_side,
   output logic                rsp_last
);
   import cfre_pkg::*;

   cfg_type    cfg_ff;
   seg_in_type req_data;
   seg_type    q_in_data, q_out_data;
   ribbon_type rib_data;
   logic       q_push, q_full, q_pop, q_empty;
   logic       rib_valid, rib_take;

   // Configuration registers; writes are always taken.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.camera_x  <= '0;
         cfg_ff.camera_y  <= '0;
         cfg_ff.camera_z  <= CAMERA_Z_RESET;
         cfg_ff.skip_thr  <= '0;
         cfg_ff.small_thr <= SMALL_THR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_CAMERA_X:  cfg_ff.camera_x  <= csr_data;
            CSR_CAMERA_Y:  cfg_ff.camera_y  <= csr_data;
            CSR_CAMERA_Z:  cfg_ff.camera_z  <= csr_data;
            CSR_SKIP_THR:  cfg_ff.skip_thr  <= csr_data[15:0];
            CSR_SMALL_THR: cfg_ff.small_thr <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_data.sx = req_start_x;
      req_data.sy = req_start_y;
      req_data.ex = req_end_x;
      req_data.ey = req_end_y;
      req_data.hs = req_start_half_width;
      req_data.he = req_end_half_width;
      req_data.r  = req_tint_r;
      req_data.g  = req_tint_g;
      req_data.b  = req_tint_b;
   end

   cfre_front u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .q_push   (q_push),
      .q_data   (q_in_data),
      .q_full   (q_full)
   );

   cfre_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .empty     (q_empty)
   );

   cfre_solver u_solver (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .q_empty   (q_empty),
      .q_data    (q_out_data),
      .q_pop     (q_pop),
      .rib_valid (rib_valid),
      .rib_data  (rib_data),
      .rib_take  (rib_take)
   );

   cfre_emit u_emit (
      .clock       (clock),
      .reset       (reset),
      .rib_valid   (rib_valid),
      .rib_data    (rib_data),
      .rib_take    (rib_take),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_pos_x   (rsp_pos_x),
      .rsp_pos_y   (rsp_pos_y),
      .rsp_pos_z   (rsp_pos_z),
      .rsp_color_r (rsp_color_r),
      .rsp_color_g (rsp_color_g),
      .rsp_color_b (rsp_color_b),
      .rsp_side    (rsp_side),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: tb/camera_facing_ribbon_expander_unit_test.sv
// Self-checking testbench for the camera-facing ribbon expander unit.
module camera_facing_ribbon_expander_unit_test;
   import cfre_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 400;

   typedef struct packed {
      logic signed [23:0] sx;
      logic signed [23:0] sy;
      logic signed [23:0] ex;
      logic signed [23:0] ey;
      logic [22:0]        hs;
      logic [22:0]        he;
      logic [15:0]        r;
      logic [15:0]        g;
      logic [15:0]        b;
   } segment_t;

   typedef struct packed {
      logic [23:0] px;
      logic [23:0] py;
      logic [23:0] pz;
      logic [15:0] r;
      logic [15:0] g;
      logic [15:0] b;
      logic        side;
      logic        last;
   } vertex_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = CSR_CAMERA_X;
   logic [23:0] csr_data = '0;
   logic req_push = 1'b0;
   logic req_full;
   logic signed [23:0] req_start_x = '0, req_start_y = '0, req_end_x = '0, req_end_y = '0;
   logic [22:0] req_start_half_width = '0, req_end_half_width = '0;
   logic [15:0] req_tint_r = '0, req_tint_g = '0, req_tint_b = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   logic signed [23:0] rsp_pos_x, rsp_pos_y, rsp_pos_z;
   logic [15:0] rsp_color_r, rsp_color_g, rsp_color_b;
   logic rsp_side, rsp_last;

   camera_facing_ribbon_expander_unit uut (.*);

   always #10 clock = ~clock;

   // Predictor copy of the configuration registers.
   longint cam_x_q = 0, cam_y_q = 0, cam_z_q = 65536, skip_q = 0, small_q = 4295;

   segment_t pending_segments[$];
   vertex_t  expected_vertices[$];
   int  failures = 0;
   int  idle_cycles = 0;
   int  send_gap = 0;

   function automatic longint isqrt(longint n);
      longint root, bitv;
      root = 0;
      bitv = 64'sd1 <<< 62;
      while (bitv > n) bitv = bitv >>> 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n = n - (root + bitv);
            root = (root >>> 1) + bitv;
         end else begin
            root = root >>> 1;
         end
         bitv = bitv >>> 2;
      end
      return root;
   endfunction

   // Divide rounding half away from zero; the divisor is positive.
   function automatic longint round_div(longint n, longint d);
      if (n >= 0) return (n + d / 2) / d;
      return -((-n + d / 2) / d);
   endfunction

   function automatic logic [23:0] clamp24(longint v);
      if (v > 8388607) return 24'h7FFFFF;
      if (v < -8388608) return 24'h800000;
      return v[23:0];
   endfunction

   // Expand one segment into its six expected vertices.
   function automatic void predict_ribbon(segment_t s);
      longint sx, sy, ex, ey, hs, he, dx, dy, seg_sq, rx, ry, rz;
      longint len, ux, uy, wx, wy, wz, w_sq, wl, vx, vy, vz, cx, cy, cz, c_sq, cl, comp;
      longint osx, osy, osz, oex, oey, oez;
      longint cxs[4], cys[4], czs[4];
      int corner_seq[6];
      vertex_t v;
      corner_seq = '{0, 2, 3, 0, 3, 1};
      sx = s.sx; sy = s.sy; ex = s.ex; ey = s.ey; hs = s.hs; he = s.he;
      dx = ex - sx; dy = ey - sy;
      seg_sq = dx * dx + dy * dy;
      if (seg_sq <= skip_q) return;
      if (seg_sq <= small_q) begin
         rx = 0; ry = 65536; rz = 0;
      end else begin
         len = isqrt(seg_sq);
         ux = round_div(dx * 65536, len);
         uy = round_div(dy * 65536, len);
         wx = 2 * cam_x_q - (sx + ex);
         wy = 2 * cam_y_q - (sy + ey);
         wz = 2 * cam_z_q;
         w_sq = wx * wx + wy * wy + wz * wz;
         // Camera sitting on the midpoint looks straight down +z.
         if (w_sq <= small_q * 4) begin
            vx = 0; vy = 0; vz = 65536;
         end else begin
            wl = isqrt(w_sq);
            vx = round_div(wx * 65536, wl);
            vy = round_div(wy * 65536, wl);
            vz = round_div(wz * 65536, wl);
         end
         cx = round_div(uy * vz, 256);
         cy = round_div(-(ux * vz), 256);
         cz = round_div(ux * vy - uy * vx, 256);
         c_sq = cx * cx + cy * cy + cz * cz;
         // Degenerate cross product falls back to a fixed axis.
         if (c_sq <= (small_q <<< 16)) begin
            comp = (uy < 62259 && uy > -62259) ? ux : -uy;
            rx = 0; ry = 0; rz = comp < 0 ? -65536 : 65536;
         end else begin
            cl = isqrt(c_sq);
            rx = round_div(cx * 65536, cl);
            ry = round_div(cy * 65536, cl);
            rz = round_div(cz * 65536, cl);
         end
      end
      osx = round_div(rx * hs, 65536); osy = round_div(ry * hs, 65536);
      osz = round_div(rz * hs, 65536);
      oex = round_div(rx * he, 65536); oey = round_div(ry * he, 65536);
      oez = round_div(rz * he, 65536);
      cxs[0] = sx - osx; cys[0] = sy - osy; czs[0] = -osz;
      cxs[1] = sx + osx; cys[1] = sy + osy; czs[1] = osz;
      cxs[2] = ex - oex; cys[2] = ey - oey; czs[2] = -oez;
      cxs[3] = ex + oex; cys[3] = ey + oey; czs[3] = oez;
      for (int k = 0; k < 6; k++) begin
         v.px = clamp24(cxs[corner_seq[k]]);
         v.py = clamp24(cys[corner_seq[k]]);
         v.pz = clamp24(czs[corner_seq[k]]);
         v.r = s.r; v.g = s.g; v.b = s.b;
         v.side = 1'(corner_seq[k] & 1);
         v.last = (k == 5);
         expected_vertices.insert(expected_vertices.size(), v);
      end
   endfunction

   // Append one segment to the driver's pending list.
   function automatic void add_segment(segment_t s);
      pending_segments.insert(pending_segments.size(), s);
   endfunction

   function automatic int random_gap();
      if ($urandom_range(0, 3) == 0) return 0;
      if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
      return $urandom_range(0, 3);
   endfunction

   // Item driver: feeds queued segments and predicts on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
      end else begin
         if (req_push && !req_full) begin
            predict_ribbon({req_start_x, req_start_y, req_end_x, req_end_y,
                            req_start_half_width, req_end_half_width,
                            req_tint_r, req_tint_g, req_tint_b});
            void'(pending_segments.pop_front());
            send_gap = random_gap();
         end
         if (send_gap > 0) begin
            send_gap--;
            req_push <= 1'b0;
         end else if (pending_segments.size() > 0) begin
            req_push <= 1'b1;
            {req_start_x, req_start_y, req_end_x, req_end_y, req_start_half_width,
             req_end_half_width, req_tint_r, req_tint_g, req_tint_b}
               <= pending_segments[0];
         end else begin
            req_push <= 1'b0;
         end
      end
   end

   // Vertex monitor: random pop stalls and field-by-field comparison.
   int pop_gap = 0;
   always @(posedge clock) begin
      vertex_t got, want;
      if (reset) begin
         rsp_pop <= 1'b0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            got = {rsp_pos_x, rsp_pos_y, rsp_pos_z, rsp_color_r, rsp_color_g,
                   rsp_color_b, rsp_side, rsp_last};
            if (expected_vertices.size() == 0) begin
               $display("%0t: unexpected vertex %h", $time, got);
               failures++;
            end else begin
               want = expected_vertices.pop_front();
               if (got.px !== want.px) begin
                  $display("%0t: pos_x exp %h got %h", $time, want.px, got.px); failures++;
               end
               if (got.py !== want.py) begin
                  $display("%0t: pos_y exp %h got %h", $time, want.py, got.py); failures++;
               end
               if (got.pz !== want.pz) begin
                  $display("%0t: pos_z exp %h got %h", $time, want.pz, got.pz); failures++;
               end
               if (got.r !== want.r || got.g !== want.g || got.b !== want.b) begin
                  $display("%0t: color exp %h %h %h got %h %h %h", $time, want.r, want.g,
                           want.b, got.r, got.g, got.b);
                  failures++;
               end
               if (got.side !== want.side) begin
                  $display("%0t: side exp %b got %b", $time, want.side, got.side); failures++;
               end
               if (got.last !== want.last) begin
                  $display("%0t: last exp %b got %b", $time, want.last, got.last); failures++;
               end
            end
            pop_gap = random_gap();
         end
         if (pop_gap > 0) begin
            pop_gap--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
         end
      end
   end

   // Watchdog on cycles with no accepted item of any kind.
   always @(posedge clock) begin
      if ((req_push && !req_full) || (rsp_pop && !rsp_empty) || (csr_valid && csr_ready)
          || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // One register write; the write channel is left idle before the task returns.
   task automatic write_reg(logic [2:0] idx, logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      case (idx)
         CSR_CAMERA_X:  cam_x_q = $signed(value);
         CSR_CAMERA_Y:  cam_y_q = $signed(value);
         CSR_CAMERA_Z:  cam_z_q = $signed(value);
         CSR_SKIP_THR:  skip_q = value[15:0];
         CSR_SMALL_THR: small_q = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Wait until the block has drained, plus its worst pass time.
   task automatic wait_idle();
      while (pending_segments.size() > 0 || expected_vertices.size() > 0 || req_push)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
         1: return 24'($signed($urandom_range(0, 8)) - 4);
         2: return 24'($signed($urandom_range(0, 2 * 65536)) - 65536);
         default: return 24'($urandom());
      endcase
   endfunction

   function automatic segment_t rand_segment();
      segment_t s;
      s.sx = rand_coord(); s.sy = rand_coord();
      case ($urandom_range(0, 5))
         // Nearly vertical or horizontal, tiny, or zero length.
         0: begin s.ex = s.sx + 24'($urandom_range(0, 4)) - 24'd2; s.ey = rand_coord(); end
         1: begin s.ey = s.sy + 24'($urandom_range(0, 4)) - 24'd2; s.ex = rand_coord(); end
         2: begin s.ex = s.sx + 24'($urandom_range(0, 6)) - 24'd3;
                  s.ey = s.sy + 24'($urandom_range(0, 6)) - 24'd3; end
         default: begin s.ex = rand_coord(); s.ey = rand_coord(); end
      endcase
      s.hs = $urandom_range(0, 3) == 0 ? 23'($urandom()) : 23'($urandom_range(0, 200000));
      s.he = $urandom_range(0, 3) == 0 ? 23'($urandom()) : 23'($urandom_range(0, 200000));
      s.r = 16'($urandom()); s.g = 16'($urandom()); s.b = 16'($urandom());
      return s;
   endfunction

   initial begin
      segment_t s;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: extremes, zero length, axis-aligned, view-aligned fallbacks.
      add_segment({24'sd0, 24'sd0, 24'sd65536, 24'sd0, 23'd4096, 23'd8192,
                   16'h0000, 16'hFFFF, 16'h1234});
      add_segment({24'sd0, 24'sd0, 24'sd0, 24'sd65536, 23'd65536, 23'd65536,
                   16'hFFFF, 16'h0000, 16'hABCD});
      add_segment({24'sd5, 24'sd5, 24'sd5, 24'sd5, 23'd100, 23'd100,
                   16'h1, 16'h2, 16'h3});
      add_segment({24'sd0, 24'sd0, 24'sd1, 24'sd1, 23'h7FFFFF, 23'h7FFFFF,
                   16'h4, 16'h5, 16'h6});
      add_segment({24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF,
                   23'h7FFFFF, 23'h7FFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF});
      add_segment({24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF,
                   23'h0, 23'h7FFFFF, 16'h0, 16'h0, 16'h0});
      add_segment({-24'sd65536, 24'sd0, 24'sd65536, 24'sd0, 23'd1000,
                   23'd1000, 16'h7, 16'h8, 16'h9});
      wait_idle();

      // Camera on the segment midpoint and in the segment plane.
      write_reg(CSR_CAMERA_X, 24'd0);
      write_reg(CSR_CAMERA_Y, 24'd0);
      write_reg(CSR_CAMERA_Z, 24'd0);
      add_segment({-24'sd65536, 24'sd0, 24'sd65536, 24'sd0, 23'd5000,
                   23'd5000, 16'h1, 16'h1, 16'h1});
      add_segment({24'sd0, -24'sd65536, 24'sd0, 24'sd65536, 23'd5000,
                   23'd5000, 16'h2, 16'h2, 16'h2});
      wait_idle();
      write_reg(CSR_CAMERA_X, 24'h7FFFFF);
      write_reg(CSR_CAMERA_Y, 24'd0);
      add_segment({24'sd0, 24'sd0, 24'sd65536, 24'sd0, 23'd5000,
                   23'd5000, 16'h3, 16'h3, 16'h3});
      add_segment({24'sd0, 24'sd0, 24'sd65536, 24'sd65536, 23'd5000,
                   23'd5000, 16'h4, 16'h4, 16'h4});
      wait_idle();

      // Random phases across several register settings.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin write_reg(CSR_SKIP_THR, 24'd0); write_reg(CSR_SMALL_THR, 24'd0); end
            1: begin write_reg(CSR_SKIP_THR, 24'd4); write_reg(CSR_SMALL_THR, 24'd65535); end
            2: begin write_reg(CSR_SKIP_THR, 24'd65535); write_reg(CSR_SMALL_THR, 24'd4295);
               end
            default: begin
               write_reg(CSR_SKIP_THR, 24'($urandom_range(0, 20)));
               write_reg(CSR_SMALL_THR, 24'($urandom_range(0, 65535)));
            end
         endcase
         write_reg(CSR_CAMERA_X, phase == 3 ? 24'h800000 : rand_coord());
         write_reg(CSR_CAMERA_Y, phase == 3 ? 24'h800000 : rand_coord());
         write_reg(CSR_CAMERA_Z, phase == 4 ? 24'h7FFFFF : rand_coord());
         for (int n = 0; n < 58; n++) begin
            s = rand_segment();
            add_segment(s);
         end
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0 && expected_vertices.size() == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/cfre_pkg.sv
design/cfre_front.sv
design/cfre_queue.sv
design/cfre_solver.sv
design/cfre_emit.sv
design/camera_facing_ribbon_expander_unit.sv
tb/camera_facing_ribbon_expander_unit_test.sv
